// ----- design/rgb_to_hsv_convert_macros.svh -----
// ---------------------------------------------------------------------------
// RGB to HSV converter assertion macros
// Shared concurrent assertion forms for the converter RTL.
// ---------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERT_MACROS_SVH
`define RGB_TO_HSV_CONVERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RHC_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("rgb_to_hsv_convert: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define RHC_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("rgb_to_hsv_convert: next-cycle check failed");

`endif

// ----- design/rhc_pkg.sv -----
// ---------------------------------------------------------------------------
// RGB to HSV converter package
// Payload types, pipeline stage record and divider constants.
// ---------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

  // Quotient bits produced by each of the two long divisions.
  localparam int QUOT_W = 16;
  // Hue divisor is six times the chroma: at most 1530, fits 11 bits.
  localparam int HUE_REM_W = 11;
  // Saturation divisor is the largest channel byte.
  localparam int SAT_REM_W = 8;
  // Default number of quotient bits resolved per pipeline stage.
  localparam int STEPS_PER_STAGE_DEF = 2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [15:0] hue;
    logic [15:0] saturation;
    logic [7:0]  brightness;
  } hsv_t;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  // One pipeline stage: partial remainders, divisors and shift registers.
  // The saturation shift register feeds dividend bits out at the top; both
  // shift registers take quotient bits in at the bottom.
  typedef struct packed {
    logic [HUE_REM_W-1:0] hue_rem;
    logic [HUE_REM_W-1:0] hue_div;
    logic [QUOT_W-1:0]    hue_shift;
    logic [SAT_REM_W-1:0] sat_rem;
    logic [SAT_REM_W-1:0] sat_div;
    logic [QUOT_W-1:0]    sat_shift;
    logic [7:0]           brightness;
  } stage_t;

endpackage

`default_nettype wire

// ----- design/rhc_div_stage.sv -----
// ---------------------------------------------------------------------------
// RGB to HSV divider stage
// Resolves STEPS quotient bits of both restoring divisions.
// ---------------------------------------------------------------------------
`default_nettype none

module rhc_div_stage #(
  parameter int STEPS = rhc_pkg::STEPS_PER_STAGE_DEF
) (
  input  wire rhc_pkg::stage_t cur,
  output rhc_pkg::stage_t      nxt
);

  logic [rhc_pkg::HUE_REM_W-1:0] h_rem;
  logic [rhc_pkg::HUE_REM_W:0]   h_trial;
  logic [rhc_pkg::QUOT_W-1:0]    h_sh;
  logic                          h_bit;
  logic [rhc_pkg::SAT_REM_W-1:0] s_rem;
  logic [rhc_pkg::SAT_REM_W:0]   s_trial;
  logic [rhc_pkg::QUOT_W-1:0]    s_sh;
  logic                          s_bit;

  always_comb begin
    h_rem   = cur.hue_rem;
    h_sh    = cur.hue_shift;
    s_rem   = cur.sat_rem;
    s_sh    = cur.sat_shift;
    h_trial = '0;
    s_trial = '0;
    h_bit   = 1'b0;
    s_bit   = 1'b0;
    for (int i = 0; i < STEPS; i++) begin
      // Hue dividend is the numerator followed by zeros.
      h_trial = {h_rem, 1'b0};
      h_bit   = (h_trial >= {1'b0, cur.hue_div});
      if (h_bit) begin
        h_rem = rhc_pkg::HUE_REM_W'(h_trial - {1'b0, cur.hue_div});
      end else begin
        h_rem = h_trial[rhc_pkg::HUE_REM_W-1:0];
      end
      h_sh = {h_sh[rhc_pkg::QUOT_W-2:0], h_bit};

      // Saturation dividend bits leave the top of the shift register.
      s_trial = {s_rem, s_sh[rhc_pkg::QUOT_W-1]};
      s_bit   = (s_trial >= {1'b0, cur.sat_div});
      if (s_bit) begin
        s_rem = rhc_pkg::SAT_REM_W'(s_trial - {1'b0, cur.sat_div});
      end else begin
        s_rem = s_trial[rhc_pkg::SAT_REM_W-1:0];
      end
      s_sh = {s_sh[rhc_pkg::QUOT_W-2:0], s_bit};
    end
    nxt           = cur;
    nxt.hue_rem   = h_rem;
    nxt.hue_shift = h_sh;
    nxt.sat_rem   = s_rem;
    nxt.sat_shift = s_sh;
  end

endmodule

`default_nettype wire

// ----- design/rgb_to_hsv_convert.sv -----
// Depth: 1 + 16/STEPS_PER_STAGE register stages.
// Throughput: one pixel per clock unless hsv_ready stalls the output; the two
//   pipelined restoring dividers set the depth, and each stage holds its item
//   while the next one cannot advance.
// Reset: synchronous, active high; clears all stage valid bits only.
// ---------------------------------------------------------------------------
// RGB to HSV converter
// Pipelined fixed-point conversion of 8-bit RGB pixels to Q0.16 hue,
// Q0.16 saturation and 8-bit value.
// ---------------------------------------------------------------------------
`default_nettype none
`include "rgb_to_hsv_convert_macros.svh"

module rgb_to_hsv_convert #(
  parameter int STEPS_PER_STAGE = rhc_pkg::STEPS_PER_STAGE_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pixel_valid,
  output logic                 pixel_ready,
  input  wire rhc_pkg::pixel_t pixel,
  output logic                 hsv_valid,
  input  wire logic            hsv_ready,
  output rhc_pkg::hsv_t        hsv
);

  // One set-up stage, then the division stages.
  localparam int NSTAGES = 1 + rhc_pkg::QUOT_W / STEPS_PER_STAGE;

  rhc_pkg::stage_t stg [NSTAGES];
  rhc_pkg::stage_t div_out [NSTAGES-1];
  logic [NSTAGES-1:0] vld;
  logic [NSTAGES:0]   en;

  // -------------------------------------------------------------------------
  // Set-up: max, min, chroma, hue numerator and the division operands.
  // -------------------------------------------------------------------------
  logic [7:0]             hi;
  logic [7:0]             lo;
  logic [7:0]             chroma;
  logic [10:0]            six_c;
  logic [11:0]            num;
  logic [23:0]            sat_dividend;
  rhc_pkg::sector_t       sector;
  rhc_pkg::stage_t        prep;

  always_comb begin
    hi = pixel.red;
    lo = pixel.red;
    if (pixel.green > hi) hi = pixel.green;
    if (pixel.blue > hi)  hi = pixel.blue;
    if (pixel.green < lo) lo = pixel.green;
    if (pixel.blue < lo)  lo = pixel.blue;
    chroma = hi - lo;
    six_c  = 11'({chroma, 2'b00}) + 11'({chroma, 1'b0});

    // Ties go to the first of red, green, blue that equals the max.
    if (hi == pixel.red) begin
      sector = rhc_pkg::SECT_RED;
    end else if (hi == pixel.green) begin
      sector = rhc_pkg::SECT_GREEN;
    end else begin
      sector = rhc_pkg::SECT_BLUE;
    end

    case (sector)
      rhc_pkg::SECT_RED: begin
        num = {4'b0, pixel.green} - {4'b0, pixel.blue};
        // Wrap a negative red-sector numerator up by a full turn.
        if (num[11]) num = num + {1'b0, six_c};
      end
      rhc_pkg::SECT_GREEN: begin
        num = 12'({chroma, 1'b0}) + {4'b0, pixel.blue} - {4'b0, pixel.red};
      end
      rhc_pkg::SECT_BLUE: begin
        num = 12'({chroma, 2'b00}) + {4'b0, pixel.red} - {4'b0, pixel.green};
      end
      default: begin
        num = '0;
      end
    endcase

    // c * 65535 as (c << 16) - c; its top byte is below max, so it seeds
    // the remainder and the low half is shifted in bit by bit.
    sat_dividend = {chroma, 16'h0000} - {16'h0000, chroma};

    prep.hue_rem    = num[rhc_pkg::HUE_REM_W-1:0];
    // A gray pixel gets an all-ones divisor so every quotient bit drops out.
    prep.hue_div    = (chroma == 8'd0) ? '1 : six_c;
    prep.hue_shift  = '0;
    prep.sat_rem    = sat_dividend[23:16];
    // Likewise for black: saturation resolves to zero.
    prep.sat_div    = (hi == 8'd0) ? '1 : hi;
    prep.sat_shift  = sat_dividend[15:0];
    prep.brightness = hi;
  end

  // -------------------------------------------------------------------------
  // Flow control: a stage advances when it is empty or the next one advances.
  // -------------------------------------------------------------------------
  assign en[NSTAGES] = hsv_ready;

  for (genvar i = 0; i < NSTAGES; i++) begin : g_en
    assign en[i] = !vld[i] || en[i+1];
  end

  assign pixel_ready = en[0];

  // Set-up stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en[0]) begin
      vld[0] <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      stg[0] <= prep;
    end
  end

  // Division stages: each resolves STEPS_PER_STAGE bits of both quotients.
  for (genvar i = 1; i < NSTAGES; i++) begin : g_div
    rhc_div_stage #(
      .STEPS (STEPS_PER_STAGE)
    ) u_div (
      .cur (stg[i-1]),
      .nxt (div_out[i-1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en[i]) begin
        vld[i] <= vld[i-1];
      end
    end

    // Hold the payload while stalled; advance it with the valid bit.
    always_ff @(posedge clk) begin
      if (en[i]) begin
        stg[i] <= div_out[i-1];
      end
    end
  end

  // The last stage register is the output register.
  assign hsv_valid       = vld[NSTAGES-1];
  assign hsv.hue         = stg[NSTAGES-1].hue_shift;
  assign hsv.saturation  = stg[NSTAGES-1].sat_shift;
  assign hsv.brightness  = stg[NSTAGES-1].brightness;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  // A transferred pixel always lands in the set-up stage.
  `RHC_ASSERT_NEXT(a_accept_fills, clk, rst, pixel_valid && pixel_ready, vld[0])
  // A stalled set-up stage keeps its item.
  `RHC_ASSERT_NEXT(a_setup_holds, clk, rst, vld[0] && !en[1], vld[0])
  // Black pixels give zero hue and zero saturation.
  `RHC_ASSERT_NOW(a_black, clk, rst, hsv_valid && (hsv.brightness == 8'd0),
                  (hsv.hue == 16'd0) && (hsv.saturation == 16'd0))
  // Any non-zero hue needs non-zero chroma, hence non-zero saturation.
  `RHC_ASSERT_NOW(a_hue_sat, clk, rst, hsv_valid && (hsv.hue != 16'd0),
                  hsv.saturation != 16'd0)

endmodule

`default_nettype wire
